@@ hw/rtl/mwsk_pkg.sv @@
// ----------------------------------------------------------------------------
// mwsk_pkg
// shared types, constants and codes of the motif window string kernel
// ----------------------------------------------------------------------------
package mwsk_pkg;

  // storage and range limits
  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned MAX_MOTIFS = 16;
  localparam int unsigned MAX_WINDOW = 256;
  localparam int unsigned MAX_DEGREE = 32;
  localparam int unsigned MAX_SHIFT  = 32;

  // datapath widths
  localparam int unsigned DIST_W     = 48;
  localparam int unsigned OUT_W      = 40;
  localparam int unsigned GAUSS_W    = 17;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned DIVIDEND_W = 36;
  localparam int unsigned DIVISOR_W  = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_A     = 2'd0,
    CMD_LOAD_B     = 2'd1,
    CMD_LOAD_MOTIF = 2'd2,
    CMD_COMPUTE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_WIDTH_RECIP  = 2'd0,
    CFG_MATCH_DEGREE = 2'd1,
    CFG_MAX_SHIFT    = 2'd2,
    CFG_WINDOW_SIZE  = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOT_RD,
    ST_MOT_LAT,
    ST_D_ACC,
    ST_P2_RD,
    ST_P2_LAT,
    ST_P2_ACC,
    ST_WIN,
    ST_RUN_RD,
    ST_RUN_CMP,
    ST_DIV_SET,
    ST_DIV_WAIT,
    ST_K_NEXT,
    ST_MOT_NEXT,
    ST_G_START,
    ST_G_WAIT,
    ST_OUT
  } main_state_e;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_PPROD,
    GS_CHECK,
    GS_XT,
    GS_DIV,
    GS_DWAIT,
    GS_SQUARE,
    GS_ROUND
  } gauss_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/mwsk_div.sv @@
// ----------------------------------------------------------------------------
// mwsk_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mwsk_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwsk_pkg::div_req_t req_i,
  output mwsk_pkg::div_rsp_t rsp_o
);

  localparam int unsigned N   = mwsk_pkg::DIVIDEND_W;
  localparam int unsigned M   = mwsk_pkg::DIVISOR_W;
  localparam int unsigned CW  = $clog2(N + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [M-1:0]  rem_q, rem_d;
  logic [M-1:0]  dvs_q, dvs_d;
  logic [M:0]    rem_sh;
  logic [M:0]    rem_diff;

  assign rem_sh   = {rem_q, quo_q[N-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_diff[M-1:0];
        quo_d = {quo_q[N-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[M-1:0];
        quo_d = {quo_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef ASSERT_OFF
  // a new division must not cut into a running one
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
`endif

`ifndef ASSERT_OFF
  // done only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without work");
`endif

endmodule

@@ hw/rtl/mwsk_gauss.sv @@
// ----------------------------------------------------------------------------
// mwsk_gauss
// fixed point exp(-dist * width_reciprocal) sequencer on one shared multiplier
// ----------------------------------------------------------------------------
module mwsk_gauss (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mwsk_pkg::DIST_W-1:0]         dist_i,
  input  logic [31:0]                         wr_i,
  output logic                                done_o,
  output logic [mwsk_pkg::GAUSS_W-1:0]        value_o,
  output mwsk_pkg::div_req_t                  div_req_o,
  input  mwsk_pkg::div_rsp_t                  div_rsp_i
);

  localparam int unsigned GW = mwsk_pkg::GAUSS_W;

  mwsk_pkg::gauss_state_e gst_q, gst_d;

  logic [1:0]    c_q, c_d;
  logic [79:0]   prod_q, prod_d;
  logic [19:0]   x_q, x_d;
  logic [31:0]   t_q, t_d;
  logic [51:0]   m_q, m_d;
  logic [3:0]    i_q, i_d;
  logic          done_q, done_d;
  logic [GW-1:0] value_q, value_d;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [15:0]   chunk;
  logic [79:0]   pp_sh;
  logic [64:0]   sq_rnd;
  logic [32:0]   t_rnd;

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (c_q)
      2'd0:    chunk = dist_i[15:0];
      2'd1:    chunk = dist_i[31:16];
      default: chunk = dist_i[47:32];
    endcase
    case (c_q)
      2'd0:    pp_sh = 80'(mul_p);
      2'd1:    pp_sh = 80'(mul_p) << 16;
      default: pp_sh = 80'(mul_p) << 32;
    endcase
  end

  assign sq_rnd = 65'(mul_p) + (65'(1) << 30);
  assign t_rnd  = 33'(t_q) + (33'(1) << 14);

  always_comb begin
    gst_d     = gst_q;
    c_d       = c_q;
    prod_d    = prod_q;
    x_d       = x_q;
    t_d       = t_q;
    m_d       = m_q;
    i_d       = i_q;
    done_d    = 1'b0;
    value_d   = value_q;
    mul_a     = '0;
    mul_b     = '0;
    div_req_o = '0;
    unique case (gst_q)
      mwsk_pkg::GS_IDLE: begin
        if (start_i) begin
          if (wr_i == '0) begin
            value_d = GW'(65536);
            done_d  = 1'b1;
          end else begin
            prod_d = '0;
            c_d    = '0;
            gst_d  = mwsk_pkg::GS_PPROD;
          end
        end
      end
      mwsk_pkg::GS_PPROD: begin
        // 48 x 32 product in three 16 bit slices
        mul_a  = 32'(chunk);
        mul_b  = wr_i;
        prod_d = prod_q + pp_sh;
        if (c_q == 2'd2) begin
          gst_d = mwsk_pkg::GS_CHECK;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      mwsk_pkg::GS_CHECK: begin
        if (prod_q >= (80'(12) << 32)) begin
          value_d = '0;
          done_d  = 1'b1;
          gst_d   = mwsk_pkg::GS_IDLE;
        end else begin
          x_d   = prod_q[35:16];
          t_d   = 32'h8000_0000;
          i_d   = 4'd10;
          gst_d = mwsk_pkg::GS_XT;
        end
      end
      mwsk_pkg::GS_XT: begin
        mul_a = 32'(x_q);
        mul_b = t_q;
        m_d   = 52'(mul_p);
        gst_d = mwsk_pkg::GS_DIV;
      end
      mwsk_pkg::GS_DIV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = mwsk_pkg::DIVIDEND_W'(m_q >> 20);
        div_req_o.divisor  = mwsk_pkg::DIVISOR_W'(i_q);
        gst_d              = mwsk_pkg::GS_DWAIT;
      end
      mwsk_pkg::GS_DWAIT: begin
        if (div_rsp_i.done) begin
          t_d = 32'h8000_0000 - div_rsp_i.quotient[31:0];
          if (i_q == 4'd1) begin
            c_d   = '0;
            gst_d = mwsk_pkg::GS_SQUARE;
          end else begin
            i_d   = i_q - 4'd1;
            gst_d = mwsk_pkg::GS_XT;
          end
        end
      end
      mwsk_pkg::GS_SQUARE: begin
        // four rounded squarings in Q31
        mul_a = t_q;
        mul_b = t_q;
        t_d   = 32'(sq_rnd >> 31);
        if (c_q == 2'd3) begin
          gst_d = mwsk_pkg::GS_ROUND;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      mwsk_pkg::GS_ROUND: begin
        value_d = GW'(t_rnd >> 15);
        done_d  = 1'b1;
        gst_d   = mwsk_pkg::GS_IDLE;
      end
      default: begin
        gst_d = mwsk_pkg::GS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q  <= mwsk_pkg::GS_IDLE;
      done_q <= 1'b0;
    end else begin
      gst_q  <= gst_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    prod_q  <= prod_d;
    x_q     <= x_d;
    t_q     <= t_d;
    m_q     <= m_d;
    i_q     <= i_d;
    value_q <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

`ifndef ASSERT_OFF
  // result never exceeds one in Q1.16
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (value_q <= GW'(65536)))
    else $error("gaussian value out of range");
`endif

endmodule

@@ hw/rtl/motif_window_string_kernel.sv @@
// ----------------------------------------------------------------------------
// motif_window_string_kernel
// string kernel: gaussian of motif distances plus windowed shifted match score
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries load and compute
//   transactions; load A, load B and load motif give no result. a compute
//   transaction gives exactly one output transaction (out_valid_o /
//   out_stall_i) with kernel_value, gaussian_part, match_part
//   steps of a compute, n = motif count:
//     distance: own term plus n pairwise terms per motif
//     match: one compare per symbol over every run of every shift,
//            plus one divide per nonzero shift accumulator (divider)
//     gaussian: partial products, then ten multiply and divide steps on
//            the shared divider, then four squarings
//   in_stall_o is high for the whole compute; one compute at a time, set by
//   the single sequencer and the single divider
//   the finished result sits in an output register; loads are still taken
//   while it waits, a following compute holds in its last state until the
//   register is free
//   reset clears the sequencers and the output valid and sets the config registers to defaults;
//   sequence and motif memories hold garbage until written
// ----------------------------------------------------------------------------
module motif_window_string_kernel #(
  parameter int unsigned MAX_LENGTH = mwsk_pkg::MAX_LENGTH,
  parameter int unsigned MAX_MOTIFS = mwsk_pkg::MAX_MOTIFS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] item_index_i,
  input  logic [7:0]  symbol_i,
  input  logic [15:0] motif_pos_a_i,
  input  logic [15:0] motif_pos_b_i,
  input  logic [12:0] length_a_i,
  input  logic [12:0] length_b_i,
  input  logic [4:0]  motif_count_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [39:0] kernel_value_o,
  output logic [16:0] gaussian_part_o,
  output logic [39:0] match_part_o
);

  localparam int unsigned AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned MW    = (MAX_MOTIFS > 1) ? $clog2(MAX_MOTIFS) : 1;
  localparam int unsigned DW    = mwsk_pkg::DIST_W;
  localparam int unsigned OW    = mwsk_pkg::OUT_W;
  localparam int unsigned GW    = mwsk_pkg::GAUSS_W;
  localparam int unsigned LW    = mwsk_pkg::LEN_W;
  localparam int unsigned AC    = mwsk_pkg::ACC_W;

  // config registers
  logic [31:0] wr_q;
  logic [5:0]  deg_cfg_q;
  logic [5:0]  shift_cfg_q;
  logic [8:0]  win_cfg_q;

  // clipped config
  logic [5:0]  deg_w;
  logic [5:0]  shifts_w;
  logic [8:0]  win_w;
  logic [11:0] sprod_w;
  logic [9:0]  s_w;
  logic [16:0] kdiv_w;

  logic in_acc;

  // memories
  logic [7:0]  seq_a_mem [MAX_LENGTH];
  logic [7:0]  seq_b_mem [MAX_LENGTH];
  logic [15:0] mpa_mem   [MAX_MOTIFS];
  logic [15:0] mpb_mem   [MAX_MOTIFS];
  logic [7:0]  sa_rd_q, sb_rd_q;
  logic [15:0] mpa_rd_q, mpb_rd_q;
  logic [AW-1:0] ra_addr, rb_addr;
  logic [MW-1:0] m_addr;

  // sequencer state
  mwsk_pkg::main_state_e state_q, state_d;

  logic [15:0]        pa_q, pa_d, pb_q, pb_d;
  logic signed [17:0] diff_q, diff_d;
  logic [DW-1:0]      dist_q, dist_d;
  logic [LW-1:0]      alen_q, alen_d, blen_q, blen_d;
  logic [8:0]         n_q, n_d;
  logic [MW-1:0]      p_q, p_d, p2_q, p2_d;
  logic [8:0]         len_q, len_d;
  logic [5:0]         k_q, k_d;
  logic [8:0]         i_q, i_d;
  logic               side_q, side_d;
  logic [5:0]         j_q, j_d;
  logic [AC-1:0]      acc_q, acc_d;
  logic [OW-1:0]      match_q, match_d;
  logic [GW-1:0]      gauss_q, gauss_d;
  logic               out_valid_q, out_valid_d;
  logic [OW-1:0]      kv_q, kv_d, mp_q, mp_d;
  logic [GW-1:0]      gp_q, gp_d;

  // datapath helpers
  logic signed [35:0] sq_w;
  logic [DW:0]        dist_add;
  logic [DW-1:0]      dist_sat;
  logic signed [17:0] e_w, d_w;
  logic signed [18:0] win_s, pa_s, pb_s, alen_s, blen_s;
  logic signed [18:0] lim_a_w, lim_b_w, lim_w;
  logic [9:0]         top_w, oa_w, ob_w;
  logic [16:0]        ra_sum, rb_sum;
  logic [5:0]         weight_w;
  logic [OW:0]        match_add;
  logic [OW:0]        kv_add;
  logic [8:0]         n_new;

  // gaussian and divider
  logic                g_start;
  logic                g_done;
  logic [GW-1:0]       g_value;
  mwsk_pkg::div_req_t  g_div_req, t_div_req, div_req;
  mwsk_pkg::div_rsp_t  div_rsp;

  assign in_stall_o = (state_q != mwsk_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // config port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= 32'd65536;
      deg_cfg_q   <= 6'd1;
      shift_cfg_q <= '0;
      win_cfg_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (mwsk_pkg::cfg_e'(cfg_index_i))
        mwsk_pkg::CFG_WIDTH_RECIP:  wr_q        <= cfg_wdata_i;
        mwsk_pkg::CFG_MATCH_DEGREE: deg_cfg_q   <= cfg_wdata_i[5:0];
        mwsk_pkg::CFG_MAX_SHIFT:    shift_cfg_q <= cfg_wdata_i[5:0];
        mwsk_pkg::CFG_WINDOW_SIZE:  win_cfg_q   <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // registers beyond their maxima count as the maximum
  assign deg_w    = (deg_cfg_q > 6'(mwsk_pkg::MAX_DEGREE)) ?
                    6'(mwsk_pkg::MAX_DEGREE) : deg_cfg_q;
  assign shifts_w = (shift_cfg_q > 6'(mwsk_pkg::MAX_SHIFT)) ?
                    6'(mwsk_pkg::MAX_SHIFT) : shift_cfg_q;
  assign win_w    = (win_cfg_q > 9'(mwsk_pkg::MAX_WINDOW)) ?
                    9'(mwsk_pkg::MAX_WINDOW) : win_cfg_q;

  // weight normalizer D(D+1)/2 and shifted divisor 2kS
  assign sprod_w = 12'(deg_w) * 12'(deg_w + 6'd1);
  assign s_w     = 10'(sprod_w >> 1);
  assign kdiv_w  = 17'(k_q) * 17'(s_w);

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == mwsk_pkg::CMD_LOAD_A) &&
        (32'(item_index_i) < MAX_LENGTH)) begin
      seq_a_mem[AW'(item_index_i)] <= symbol_i;
    end
    sa_rd_q <= seq_a_mem[ra_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == mwsk_pkg::CMD_LOAD_B) &&
        (32'(item_index_i) < MAX_LENGTH)) begin
      seq_b_mem[AW'(item_index_i)] <= symbol_i;
    end
    sb_rd_q <= seq_b_mem[rb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == mwsk_pkg::CMD_LOAD_MOTIF) &&
        (32'(item_index_i) < MAX_MOTIFS)) begin
      mpa_mem[MW'(item_index_i)] <= motif_pos_a_i;
      mpb_mem[MW'(item_index_i)] <= motif_pos_b_i;
    end
    mpa_rd_q <= mpa_mem[m_addr];
    mpb_rd_q <= mpb_mem[m_addr];
  end

  assign m_addr = (state_q == mwsk_pkg::ST_MOT_RD) ? p_q : p2_q;

  // run offsets: shift k puts A ahead on the first side, B on the second
  assign top_w   = 10'(i_q) + 10'(k_q);
  assign oa_w    = side_q ? 10'(i_q) : top_w;
  assign ob_w    = side_q ? top_w : 10'(i_q);
  assign ra_sum  = 17'(pa_q) + 17'(oa_w) + 17'(j_q);
  assign rb_sum  = 17'(pb_q) + 17'(ob_w) + 17'(j_q);
  assign ra_addr = ra_sum[AW-1:0];
  assign rb_addr = rb_sum[AW-1:0];

  // --------------------------------------------------------------------------
  // arithmetic
  // --------------------------------------------------------------------------
  // shared squarer for both distance terms, saturating at 48 bits
  assign sq_w     = diff_q * diff_q;
  assign dist_add = (DW+1)'(dist_q) + (DW+1)'($unsigned(sq_w));
  assign dist_sat = dist_add[DW] ? '1 : dist_add[DW-1:0];

  assign d_w = $signed({2'b00, mpa_rd_q}) - $signed({2'b00, mpb_rd_q});
  assign e_w = $signed({2'b00, pa_q}) - $signed({2'b00, mpa_rd_q})
             - $signed({2'b00, pb_q}) + $signed({2'b00, mpb_rd_q});

  // window clipped at both sequence ends
  assign win_s   = signed'(19'(win_w));
  assign pa_s    = signed'(19'(pa_q));
  assign pb_s    = signed'(19'(pb_q));
  assign alen_s  = signed'(19'(alen_q));
  assign blen_s  = signed'(19'(blen_q));
  assign lim_a_w = (win_s + pa_s > alen_s) ? (alen_s - pa_s) : win_s;
  assign lim_b_w = blen_s - pb_s;
  assign lim_w   = ((win_s + pb_s > blen_s) && (lim_b_w < lim_a_w)) ? lim_b_w : lim_a_w;

  assign weight_w  = deg_w - j_q;
  assign match_add = (OW+1)'(match_q) + (OW+1)'(div_rsp.quotient);
  assign kv_add    = (OW+1)'(gauss_q) + (OW+1)'(match_q);

  assign n_new = (32'(motif_count_i) > MAX_MOTIFS) ? 9'(MAX_MOTIFS) : 9'(motif_count_i);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    diff_d      = diff_q;
    dist_d      = dist_q;
    alen_d      = alen_q;
    blen_d      = blen_q;
    n_d         = n_q;
    p_d         = p_q;
    p2_d        = p2_q;
    len_d       = len_q;
    k_d         = k_q;
    i_d         = i_q;
    side_d      = side_q;
    j_d         = j_q;
    acc_d       = acc_q;
    match_d     = match_q;
    gauss_d     = gauss_q;
    kv_d        = kv_q;
    gp_d        = gp_q;
    mp_d        = mp_q;
    out_valid_d = out_valid_q && out_stall_i;
    g_start     = 1'b0;
    t_div_req   = '0;

    unique case (state_q)
      mwsk_pkg::ST_IDLE: begin
        if (in_acc && (command_i == mwsk_pkg::CMD_COMPUTE)) begin
          alen_d  = (32'(length_a_i) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(length_a_i);
          blen_d  = (32'(length_b_i) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(length_b_i);
          n_d     = n_new;
          dist_d  = '0;
          match_d = '0;
          p_d     = '0;
          state_d = (n_new == '0) ? mwsk_pkg::ST_G_START : mwsk_pkg::ST_MOT_RD;
        end
      end
      mwsk_pkg::ST_MOT_RD: begin
        state_d = mwsk_pkg::ST_MOT_LAT;
      end
      mwsk_pkg::ST_MOT_LAT: begin
        pa_d    = mpa_rd_q;
        pb_d    = mpb_rd_q;
        diff_d  = d_w;
        p2_d    = '0;
        state_d = mwsk_pkg::ST_D_ACC;
      end
      mwsk_pkg::ST_D_ACC: begin
        // own position difference squared
        dist_d  = dist_sat;
        state_d = mwsk_pkg::ST_P2_RD;
      end
      mwsk_pkg::ST_P2_RD: begin
        state_d = mwsk_pkg::ST_P2_LAT;
      end
      mwsk_pkg::ST_P2_LAT: begin
        diff_d  = e_w;
        state_d = mwsk_pkg::ST_P2_ACC;
      end
      mwsk_pkg::ST_P2_ACC: begin
        // pairwise offset difference squared, every pair seen twice
        dist_d = dist_sat;
        if (9'(p2_q) + 9'd1 < n_q) begin
          p2_d    = p2_q + MW'(1);
          state_d = mwsk_pkg::ST_P2_RD;
        end else begin
          state_d = mwsk_pkg::ST_WIN;
        end
      end
      mwsk_pkg::ST_WIN: begin
        if ((lim_w > 19'sd0) && (deg_w != '0)) begin
          len_d   = 9'(lim_w);
          k_d     = '0;
          i_d     = '0;
          side_d  = 1'b0;
          j_d     = '0;
          acc_d   = '0;
          state_d = mwsk_pkg::ST_RUN_RD;
        end else begin
          state_d = mwsk_pkg::ST_MOT_NEXT;
        end
      end
      mwsk_pkg::ST_RUN_RD: begin
        state_d = mwsk_pkg::ST_RUN_CMP;
      end
      mwsk_pkg::ST_RUN_CMP: begin
        if ((sa_rd_q == sb_rd_q) &&
            (7'(j_q) + 7'd1 < 7'(deg_w)) &&
            (11'(top_w) + 11'(j_q) + 11'd1 < 11'(len_q))) begin
          // run goes on
          acc_d   = acc_q + AC'(weight_w);
          j_d     = j_q + 6'd1;
          state_d = mwsk_pkg::ST_RUN_RD;
        end else begin
          if (sa_rd_q == sb_rd_q) begin
            acc_d = acc_q + AC'(weight_w);
          end
          j_d = '0;
          if (k_q == '0) begin
            if (10'(i_q) + 10'd1 < 10'(len_q)) begin
              i_d     = i_q + 9'd1;
              state_d = mwsk_pkg::ST_RUN_RD;
            end else begin
              state_d = mwsk_pkg::ST_DIV_SET;
            end
          end else if (!side_q) begin
            side_d  = 1'b1;
            state_d = mwsk_pkg::ST_RUN_RD;
          end else begin
            side_d = 1'b0;
            if (top_w + 10'd1 < 10'(len_q)) begin
              i_d     = i_q + 9'd1;
              state_d = mwsk_pkg::ST_RUN_RD;
            end else begin
              state_d = mwsk_pkg::ST_DIV_SET;
            end
          end
        end
      end
      mwsk_pkg::ST_DIV_SET: begin
        if (acc_q == '0) begin
          state_d = mwsk_pkg::ST_K_NEXT;
        end else begin
          t_div_req.start    = 1'b1;
          t_div_req.dividend = {acc_q, 16'h0000};
          t_div_req.divisor  = (k_q == '0) ? mwsk_pkg::DIVISOR_W'(s_w) :
                               mwsk_pkg::DIVISOR_W'(kdiv_w << 1);
          state_d            = mwsk_pkg::ST_DIV_WAIT;
        end
      end
      mwsk_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          match_d = match_add[OW] ? '1 : match_add[OW-1:0];
          state_d = mwsk_pkg::ST_K_NEXT;
        end
      end
      mwsk_pkg::ST_K_NEXT: begin
        // shifts up to the configured maximum as long as the window leaves room
        if ((k_q < shifts_w) && (10'(k_q) + 10'd1 < 10'(len_q))) begin
          k_d     = k_q + 6'd1;
          i_d     = '0;
          side_d  = 1'b0;
          j_d     = '0;
          acc_d   = '0;
          state_d = mwsk_pkg::ST_RUN_RD;
        end else begin
          state_d = mwsk_pkg::ST_MOT_NEXT;
        end
      end
      mwsk_pkg::ST_MOT_NEXT: begin
        if (9'(p_q) + 9'd1 < n_q) begin
          p_d     = p_q + MW'(1);
          state_d = mwsk_pkg::ST_MOT_RD;
        end else begin
          state_d = mwsk_pkg::ST_G_START;
        end
      end
      mwsk_pkg::ST_G_START: begin
        g_start = 1'b1;
        state_d = mwsk_pkg::ST_G_WAIT;
      end
      mwsk_pkg::ST_G_WAIT: begin
        if (g_done) begin
          gauss_d = g_value;
          state_d = mwsk_pkg::ST_OUT;
        end
      end
      mwsk_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          kv_d        = kv_add[OW] ? '1 : kv_add[OW-1:0];
          gp_d        = gauss_q;
          mp_d        = match_q;
          out_valid_d = 1'b1;
          state_d     = mwsk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mwsk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwsk_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    diff_q  <= diff_d;
    dist_q  <= dist_d;
    alen_q  <= alen_d;
    blen_q  <= blen_d;
    n_q     <= n_d;
    p_q     <= p_d;
    p2_q    <= p2_d;
    len_q   <= len_d;
    k_q     <= k_d;
    i_q     <= i_d;
    side_q  <= side_d;
    j_q     <= j_d;
    acc_q   <= acc_d;
    match_q <= match_d;
    gauss_q <= gauss_d;
    kv_q    <= kv_d;
    gp_q    <= gp_d;
    mp_q    <= mp_d;
  end

  // --------------------------------------------------------------------------
  // gaussian unit and shared divider
  // --------------------------------------------------------------------------
  mwsk_gauss u_gauss (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (g_start),
    .dist_i    (dist_q),
    .wr_i      (wr_q),
    .done_o    (g_done),
    .value_o   (g_value),
    .div_req_o (g_div_req),
    .div_rsp_i (div_rsp)
  );

  // the two requesters never overlap
  assign div_req = g_div_req.start ? g_div_req : t_div_req;

  mwsk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o     = out_valid_q;
  assign kernel_value_o  = kv_q;
  assign gaussian_part_o = gp_q;
  assign match_part_o    = mp_q;

`ifndef ASSERT_OFF
  // every compare uses data read in the cycle before
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwsk_pkg::ST_RUN_CMP) |-> ($past(state_q) == mwsk_pkg::ST_RUN_RD))
    else $error("symbol compare without read");
`endif

`ifndef ASSERT_OFF
  // runs stay inside the window and the degree
  a_run_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwsk_pkg::ST_RUN_RD) |-> ((len_q != '0) && (j_q < deg_w)))
    else $error("run outside window or degree");
`endif

`ifndef ASSERT_OFF
  // empty accumulators skip the divider
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwsk_pkg::ST_DIV_WAIT) |-> (acc_q != '0))
    else $error("division of an empty accumulator");
`endif

endmodule
